FILE: design/salc_pkg.sv
// ----------------------------------------------------------------------------
// salc_pkg
// shared types, codes and field widths of the set-associative lru cache model
// ----------------------------------------------------------------------------
package salc_pkg;

  localparam int ADDR_W      = 63;
  localparam int KIND_W      = 2;
  localparam int OUTCOME_W   = 2;
  localparam int TOTAL_W     = 32;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 6;
  localparam int SHIFT_W     = 7;
  localparam int IN_TDATA_W  = 64;
  localparam int IN_PAD_W    = IN_TDATA_W - ADDR_W;
  localparam int OUT_TDATA_W = 104;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUTCOME_W - 3 * TOTAL_W;

  localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_STORE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_MODIFY = 2'd2;

  localparam logic [OUTCOME_W-1:0] OUTCOME_HIT   = 2'd0;
  localparam logic [OUTCOME_W-1:0] OUTCOME_MISS  = 2'd1;
  localparam logic [OUTCOME_W-1:0] OUTCOME_EVICT = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] REG_SET_INDEX_BITS    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_OFFSET_BITS = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_WAYS_IN_USE       = 2'd2;

  typedef struct packed {
    logic [2:0] set_index_bits;
    logic [5:0] block_offset_bits;
    logic [2:0] ways_in_use;
  } cfg_t;

  typedef struct packed {
    logic valid;
    logic two;
  } lq_stat_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_EVAL,
    BK_SECOND
  } back_state_t;

endpackage

FILE: design/salc_front.sv
// ----------------------------------------------------------------------------
// salc_front
// accepts access beats, splits the address into set and tag, queues lookups
// ----------------------------------------------------------------------------
module salc_front
  import salc_pkg::*;
#(
  parameter int MAX_SET_INDEX_BITS = 6,
  parameter int SET_W              = 6
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cfg_t                  cfg,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_TDATA_W-1:0] s_tdata,
  input  logic [KIND_W-1:0]     s_tuser,
  output lq_stat_t              q_stat,
  output logic [SET_W-1:0]      q_set,
  output logic [ADDR_W-1:0]     q_tag,
  input  logic                  q_pop
);

  logic [ADDR_W-1:0]  addr;
  logic [2:0]         sbits;
  logic [ADDR_W-1:0]  shifted;
  logic [SET_W-1:0]   set_mask;
  logic [SET_W-1:0]   in_set;
  logic [SHIFT_W-1:0] tag_shift;
  logic [ADDR_W-1:0]  in_tag;
  logic               push;

  logic [SET_W-1:0]   set_q [2];
  logic [ADDR_W-1:0]  tag_q [2];
  logic [1:0]         two_q;
  logic               wr_ptr;
  logic               rd_ptr;
  logic [1:0]         count;

  always_comb begin
    addr      = s_tdata[ADDR_W-1:0];
    sbits     = (int'(cfg.set_index_bits) > MAX_SET_INDEX_BITS) ?
                3'(MAX_SET_INDEX_BITS) : cfg.set_index_bits;
    shifted   = addr >> cfg.block_offset_bits;
    set_mask  = ~({SET_W{1'b1}} << sbits);
    in_set    = shifted[SET_W-1:0] & set_mask;
    tag_shift = {1'b0, cfg.block_offset_bits} + {4'b0, sbits};
    in_tag    = addr >> tag_shift;
  end

  assign s_tready = (count != 2'd2);
  assign push     = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (push) begin
      set_q[wr_ptr] <= in_set;
      tag_q[wr_ptr] <= in_tag;
      two_q[wr_ptr] <= (s_tuser == KIND_MODIFY);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, q_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  assign q_stat.valid = (count != 2'd0);
  assign q_stat.two   = two_q[rd_ptr];
  assign q_set        = set_q[rd_ptr];
  assign q_tag        = tag_q[rd_ptr];

endmodule

FILE: design/salc_back.sv
// ----------------------------------------------------------------------------
// salc_back
// lookup engine: reads a set, picks hit or lru victim, writes back, reports
// ----------------------------------------------------------------------------
module salc_back
  import salc_pkg::*;
#(
  parameter int MAX_WAYS = 4,
  parameter int SET_W    = 6
) (
  input  logic                   clk,
  input  logic                   rst,
  input  cfg_t                   cfg,
  input  lq_stat_t               q_stat,
  input  logic [SET_W-1:0]       q_set,
  input  logic [ADDR_W-1:0]      q_tag,
  output logic                   q_pop,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,
  output logic                   m_tlast
);

  localparam int NUM_SETS = 1 << SET_W;
  localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WCNT_W   = $clog2(MAX_WAYS + 1);

  typedef logic [MAX_WAYS-1:0][ADDR_W-1:0] tag_row_t;
  typedef logic [MAX_WAYS-1:0][WAY_W-1:0]  rec_row_t;

  tag_row_t             tag_mem [NUM_SETS];
  rec_row_t             rec_mem [NUM_SETS];
  logic [MAX_WAYS-1:0]  line_valid [NUM_SETS];
  logic [NUM_SETS-1:0]  rec_init;

  tag_row_t             rd_tags;
  rec_row_t             rd_rec;

  back_state_t          state;
  back_state_t          state_next;
  logic                 second;
  logic                 rd_en;
  logic                 commit;
  logic                 last;

  logic [TOTAL_W-1:0]   hit_cnt;
  logic [TOTAL_W-1:0]   miss_cnt;
  logic [TOTAL_W-1:0]   evict_cnt;
  logic [OUTCOME_W-1:0] outcome;
  logic [OUTCOME_W-1:0] outcome_next;

  logic [WCNT_W-1:0]    ways;
  rec_row_t             reset_order;
  rec_row_t             rec_cur;
  rec_row_t             rec_next;
  tag_row_t             tag_row_next;
  logic [MAX_WAYS-1:0]  valid_row;
  logic                 hit;
  logic [WAY_W-1:0]     hit_way;
  logic [WAY_W-1:0]     vic_pos;
  logic [WAY_W-1:0]     victim;
  logic [WAY_W-1:0]     touch_way;
  logic [WAY_W-1:0]     touch_pos;
  logic                 touch_found;

  always_comb begin
    for (int i = 0; i < MAX_WAYS; i++) begin
      reset_order[i] = WAY_W'(i);
    end
  end

  // lookup evaluation on the registered set row
  always_comb begin
    if (cfg.ways_in_use == 3'd0) begin
      ways = WCNT_W'(1);
    end else if (int'(cfg.ways_in_use) > MAX_WAYS) begin
      ways = WCNT_W'(MAX_WAYS);
    end else begin
      ways = WCNT_W'(cfg.ways_in_use);
    end

    valid_row = line_valid[q_set];
    rec_cur   = rec_init[q_set] ? rd_rec : reset_order;

    hit     = 1'b0;
    hit_way = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (w < int'(ways) && valid_row[w] && rd_tags[w] == q_tag) begin
        hit     = 1'b1;
        hit_way = WAY_W'(w);
      end
    end

    vic_pos = '0;
    for (int p = MAX_WAYS - 1; p >= 0; p--) begin
      if (int'(rec_cur[p]) < int'(ways)) begin
        vic_pos = WAY_W'(p);
      end
    end
    victim = rec_cur[vic_pos];

    touch_way   = hit ? hit_way : victim;
    touch_pos   = vic_pos;
    touch_found = !hit;
    if (hit) begin
      for (int p = MAX_WAYS - 1; p >= 0; p--) begin
        if (rec_cur[p] == hit_way) begin
          touch_pos   = WAY_W'(p);
          touch_found = 1'b1;
        end
      end
    end

    rec_next = rec_cur;
    if (touch_found) begin
      for (int i = 0; i < MAX_WAYS - 1; i++) begin
        rec_next[i] = (i < int'(touch_pos)) ? rec_cur[i] : rec_cur[i+1];
      end
      rec_next[MAX_WAYS-1] = touch_way;
    end

    tag_row_next         = rd_tags;
    tag_row_next[victim] = q_tag;

    if (hit) begin
      outcome_next = OUTCOME_HIT;
    end else if (valid_row[victim]) begin
      outcome_next = OUTCOME_EVICT;
    end else begin
      outcome_next = OUTCOME_MISS;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    rd_en      = 1'b0;
    commit     = 1'b0;
    last       = !q_stat.two || second;
    unique case (state)
      BK_IDLE: begin
        if (q_stat.valid) begin
          rd_en      = 1'b1;
          state_next = BK_EVAL;
        end
      end
      BK_EVAL: begin
        if (!m_tvalid || m_tready) begin
          commit     = 1'b1;
          state_next = last ? BK_IDLE : BK_SECOND;
        end
      end
      BK_SECOND: begin
        rd_en      = 1'b1;
        state_next = BK_EVAL;
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  assign q_pop = commit && last;

  // set memories
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_tags <= tag_mem[q_set];
      rd_rec  <= rec_mem[q_set];
    end
    if (commit) begin
      rec_mem[q_set] <= rec_next;
      if (!hit) begin
        tag_mem[q_set] <= tag_row_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < NUM_SETS; s++) begin
        line_valid[s] <= '0;
      end
      rec_init <= '0;
    end else if (commit) begin
      rec_init[q_set] <= 1'b1;
      if (!hit) begin
        line_valid[q_set][victim] <= 1'b1;
      end
    end
  end

  // totals and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      hit_cnt   <= '0;
      miss_cnt  <= '0;
      evict_cnt <= '0;
      second    <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      if (commit) begin
        second   <= !last;
        m_tvalid <= 1'b1;
        if (hit) begin
          hit_cnt <= (hit_cnt == '1) ? hit_cnt : hit_cnt + 1'b1;
        end else begin
          miss_cnt <= (miss_cnt == '1) ? miss_cnt : miss_cnt + 1'b1;
        end
        if (outcome_next == OUTCOME_EVICT) begin
          evict_cnt <= (evict_cnt == '1) ? evict_cnt : evict_cnt + 1'b1;
        end
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      outcome <= outcome_next;
      m_tlast <= last;
    end
  end

  assign m_tdata = {{OUT_PAD_W{1'b0}}, evict_cnt, miss_cnt, hit_cnt, outcome};

endmodule

FILE: design/set_assoc_lru_cache_model_top.sv
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_model_top
// tag-only set-associative cache model with lru replacement and hit totals
// ----------------------------------------------------------------------------
// usage:
//   s_* channel takes one access per beat: kind on s_tuser, address on s_tdata.
//   loads and stores give one result beat, a modify gives two; m_tlast marks
//   the final beat of an access. each result carries the outcome code and
//   the saturating hit, miss and eviction totals including that lookup.
//   cfg_we/cfg_index/cfg_data write set index bits, block offset bits and
//   ways in use; write only while no access is in flight.
//   a two-entry queue sits between the classifying front and the lookup
//   engine, so accesses keep being taken while a result waits on m_tready.
//   an accepted access is queued, its set row is read into a register and
//   the lookup result is then registered. each lookup reads its set from
//   the per-set tag and recency memories through a single read port, then
//   compares, updates recency and writes the set back; a modify does this
//   twice, one lookup at a time. reset clears config, totals, valid bits
//   and recency order; there is no clearing pass. a stalled m_tready holds
//   the result beat and the engine waits before writing back the next lookup.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_model_top
  import salc_pkg::*;
#(
  parameter int MAX_SET_INDEX_BITS = 6,
  parameter int MAX_WAYS           = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // address[62:0], zero pad[63]
  input  logic [KIND_W-1:0]      s_tuser,   // kind[1:0]
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // outcome[1:0], hit_total[33:2],
                                            // miss_total[65:34],
                                            // eviction_total[97:66], pad
  output logic                   m_tlast
);

  localparam int SET_W = (MAX_SET_INDEX_BITS > 0) ? MAX_SET_INDEX_BITS : 1;

  cfg_t              cfg;
  lq_stat_t          q_stat;
  logic [SET_W-1:0]  q_set;
  logic [ADDR_W-1:0] q_tag;
  logic              q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.set_index_bits    <= 3'd0;
      cfg.block_offset_bits <= 6'd0;
      cfg.ways_in_use       <= 3'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SET_INDEX_BITS:    cfg.set_index_bits    <= cfg_data[2:0];
        REG_BLOCK_OFFSET_BITS: cfg.block_offset_bits <= cfg_data;
        REG_WAYS_IN_USE:       cfg.ways_in_use       <= cfg_data[2:0];
        default: begin
        end
      endcase
    end
  end

  salc_front #(
    .MAX_SET_INDEX_BITS (MAX_SET_INDEX_BITS),
    .SET_W              (SET_W)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_stat   (q_stat),
    .q_set    (q_set),
    .q_tag    (q_tag),
    .q_pop    (q_pop)
  );

  salc_back #(
    .MAX_WAYS (MAX_WAYS),
    .SET_W    (SET_W)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_stat   (q_stat),
    .q_set    (q_set),
    .q_tag    (q_tag),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

FILE: design/salc_check.sv
// ----------------------------------------------------------------------------
// salc_check
// port-level checks on the result channel of the cache model
// ----------------------------------------------------------------------------
module salc_check
  import salc_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata,
  input logic                   m_tlast
);

  logic [OUTCOME_W-1:0] res_outcome;
  logic [TOTAL_W-1:0]   res_hits;
  logic [TOTAL_W-1:0]   res_misses;
  logic [TOTAL_W-1:0]   res_evicts;

  assign res_outcome = m_tdata[1:0];
  assign res_hits    = m_tdata[33:2];
  assign res_misses  = m_tdata[65:34];
  assign res_evicts  = m_tdata[97:66];

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result beat changed while stalled");

  a_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> res_outcome == OUTCOME_HIT || res_outcome == OUTCOME_MISS ||
                 res_outcome == OUTCOME_EVICT)
    else $error("illegal outcome code");

  a_counted: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (res_outcome == OUTCOME_HIT) ? (res_hits != '0) : (res_misses != '0))
    else $error("outcome not reflected in totals");

  a_evict_le_miss: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> res_evicts <= res_misses)
    else $error("evictions exceed misses");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind set_assoc_lru_cache_model_top salc_check u_check (.*);

FILE: sim/salc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salc_checker
// watches the config port and both access streams, keeps its own tag-only
// lru cache image, predicts each lookup result beat and compares it in order
// ----------------------------------------------------------------------------
module salc_checker
  import salc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // address[62:0], zero pad[63]
  input  logic [KIND_W-1:0]      s_tuser,   // kind[1:0]
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  input  logic [OUT_TDATA_W-1:0] m_tdata,   // outcome[1:0], hit_total[33:2],
                                            // miss_total[65:34],
                                            // eviction_total[97:66], pad
  input  logic                   m_tlast,
  output int                     errors,
  output int                     outstanding
);

  localparam int SETS    = 64;
  localparam int WAYS    = 4;
  localparam int MAX_SIB = 6;

  typedef struct packed {
    logic [OUTCOME_W-1:0] outcome;
    logic                 last;
    logic [TOTAL_W-1:0]   hits;
    logic [TOTAL_W-1:0]   misses;
    logic [TOTAL_W-1:0]   evictions;
  } lookup_result_t;

  lookup_result_t     lookup_q[$];
  logic [63:0]        line_tag  [SETS][WAYS];
  logic               line_vld  [SETS][WAYS];
  int unsigned        age_order [SETS][WAYS];
  logic [TOTAL_W-1:0] hit_cnt;
  logic [TOTAL_W-1:0] miss_cnt;
  logic [TOTAL_W-1:0] evict_cnt;
  logic [2:0]         set_bits;
  logic [5:0]         offset_bits;
  logic [2:0]         ways_cfg;

  function automatic logic [TOTAL_W-1:0] bump(input logic [TOTAL_W-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  // move a way to the newest end of its set
  function automatic void make_newest(input int s, input int unsigned w);
    int p;
    p = 0;
    while (p < WAYS && age_order[s][p] != w) p++;
    for (; p < WAYS - 1; p++) age_order[s][p] = age_order[s][p + 1];
    age_order[s][WAYS - 1] = w;
  endfunction

  function automatic logic [OUTCOME_W-1:0] cache_lookup(input logic [ADDR_W-1:0] addr);
    int                   sb;
    int                   nw;
    int                   s;
    int unsigned          victim;
    logic [63:0]          a;
    logic [63:0]          tag;
    logic [OUTCOME_W-1:0] res;
    sb = (set_bits > MAX_SIB) ? MAX_SIB : int'(set_bits);
    nw = (ways_cfg == 0) ? 1 : ((ways_cfg > WAYS) ? WAYS : int'(ways_cfg));
    a = {1'b0, addr};
    s = int'((a >> offset_bits) & ((64'd1 << sb) - 64'd1));
    tag = a >> (int'(offset_bits) + sb);
    for (int w = 0; w < nw; w++) begin
      if (line_vld[s][w] && line_tag[s][w] == tag) begin
        make_newest(s, w);
        hit_cnt = bump(hit_cnt);
        return OUTCOME_HIT;
      end
    end
    victim = 0;
    for (int p = 0; p < WAYS; p++) begin
      if (age_order[s][p] < nw) begin
        victim = age_order[s][p];
        break;
      end
    end
    res = line_vld[s][victim] ? OUTCOME_EVICT : OUTCOME_MISS;
    miss_cnt = bump(miss_cnt);
    if (res == OUTCOME_EVICT) evict_cnt = bump(evict_cnt);
    line_tag[s][victim] = tag;
    line_vld[s][victim] = 1'b1;
    make_newest(s, victim);
    return res;
  endfunction

  function automatic void check_field(input string name, input logic [TOTAL_W-1:0] want,
                                      input logic [TOTAL_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    lookup_result_t   got;
    lookup_result_t   want;
    lookup_result_t   r;
    logic [ADDR_W-1:0] addr;
    int               n;
    if (rst) begin
      for (int s = 0; s < SETS; s++) begin
        for (int w = 0; w < WAYS; w++) begin
          line_vld[s][w]  = 1'b0;
          age_order[s][w] = w;
        end
      end
      hit_cnt     = '0;
      miss_cnt    = '0;
      evict_cnt   = '0;
      set_bits    = '0;
      offset_bits = '0;
      ways_cfg    = 3'd1;
      errors      = 0;
      lookup_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got.outcome   = m_tdata[OUTCOME_W-1:0];
        got.last      = m_tlast;
        got.hits      = m_tdata[OUTCOME_W +: TOTAL_W];
        got.misses    = m_tdata[OUTCOME_W + TOTAL_W +: TOTAL_W];
        got.evictions = m_tdata[OUTCOME_W + 2 * TOTAL_W +: TOTAL_W];
        if (lookup_q.size() == 0) begin
          $display("%0t: result beat with no lookup waiting, outcome %0d hits %0d",
                   $time, got.outcome, got.hits);
          errors++;
        end else begin
          want = lookup_q.pop_front();
          check_field("outcome", TOTAL_W'(want.outcome), TOTAL_W'(got.outcome));
          check_field("last", TOTAL_W'(want.last), TOTAL_W'(got.last));
          check_field("hit_total", want.hits, got.hits);
          check_field("miss_total", want.misses, got.misses);
          check_field("eviction_total", want.evictions, got.evictions);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_SET_INDEX_BITS:    set_bits    = cfg_data[2:0];
          REG_BLOCK_OFFSET_BITS: offset_bits = cfg_data[5:0];
          REG_WAYS_IN_USE:       ways_cfg    = cfg_data[2:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        addr = s_tdata[ADDR_W-1:0];
        n = (s_tuser == KIND_MODIFY) ? 2 : 1;
        for (int k = 0; k < n; k++) begin
          r.outcome   = cache_lookup(addr);
          r.last      = (k == n - 1);
          r.hits      = hit_cnt;
          r.misses    = miss_cnt;
          r.evictions = evict_cnt;
          lookup_q.push_back(r);
        end
      end
    end
    outstanding = lookup_q.size();
  end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives accesses and config writes into the lru cache model with random
// gaps and back-pressure; the checker predicts and compares every result
// ----------------------------------------------------------------------------
module testbench
  import salc_pkg::*;
;

  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
  localparam int                PHASES     = 13;
  localparam int                PHASE_LEN  = 150;
  localparam logic [ADDR_W-1:0] ADDR_ONES  = '1;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic [KIND_W-1:0]      s_tuser = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tlast;
  int                     errors;
  int                     outstanding;
  logic                   calm = 1'b0;

  int                     cur_sib;
  int                     cur_bob;
  logic [63:0]            pool_tag [6];
  logic [63:0]            pool_set [3];

  set_assoc_lru_cache_model_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  salc_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast),
    .errors      (errors),
    .outstanding (outstanding)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(negedge clk) begin
    m_tready <= calm || ($urandom_range(99) >= 14);
  end

  initial begin
    #2000000;
    $display("testbench: errors");
    $finish;
  end

  task automatic send(input logic [KIND_W-1:0] kind, input logic [ADDR_W-1:0] addr);
    while (!calm && $urandom_range(99) < 14) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{IN_PAD_W{1'b0}}, addr};
    s_tuser  <= kind;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // drain every result, then give the pipeline time to empty
  task automatic settle();
    s_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic apply_config(input int sib, input int bob, input int ways);
    cfg_we    <= 1'b1;
    cfg_index <= REG_SET_INDEX_BITS;
    cfg_data  <= CFG_DATA_W'(sib);
    @(negedge clk);
    cfg_index <= REG_BLOCK_OFFSET_BITS;
    cfg_data  <= CFG_DATA_W'(bob);
    @(negedge clk);
    cfg_index <= REG_WAYS_IN_USE;
    cfg_data  <= CFG_DATA_W'(ways);
    @(negedge clk);
    cfg_we    <= 1'b0;
    cur_sib = (sib > 6) ? 6 : sib;
    cur_bob = bob;
  endtask

  // mostly a few tags over a few sets so hits and evictions both happen
  function automatic logic [ADDR_W-1:0] pick_address();
    logic [63:0] a;
    logic [63:0] off;
    if ($urandom_range(99) < 15) return ADDR_W'({$urandom, $urandom});
    off = {$urandom, $urandom};
    a = (pool_tag[$urandom_range(0, 5)] << (cur_bob + cur_sib))
        | (pool_set[$urandom_range(0, 2)] << cur_bob)
        | (off & ((64'd1 << cur_bob) - 64'd1));
    return a[ADDR_W-1:0];
  endfunction

  initial begin
    int fixed_sib  [6] = '{0, 6, 7, 3, 1, 6};
    int fixed_bob  [6] = '{0, 6, 63, 32, 2, 0};
    int fixed_ways [6] = '{1, 4, 7, 0, 2, 3};
    int sib;
    int bob;
    int ways;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // one set, one way
    send(KIND_LOAD, '0);
    send(KIND_STORE, '0);
    send(KIND_MODIFY, 63'd1);
    send(KIND_SPARE, ADDR_ONES);
    send(KIND_LOAD, ADDR_ONES);
    send(KIND_MODIFY, ADDR_ONES);
    settle();

    // too many set bits, no ways, offset covering the whole address
    apply_config(7, 63, 0);
    send(KIND_LOAD, ADDR_W'({$urandom, $urandom}));
    send(KIND_STORE, ADDR_ONES);
    send(KIND_MODIFY, '0);
    send(KIND_SPARE, 63'd1);
    settle();

    // fill one set past its ways and walk the lru order
    apply_config(2, 4, 7);
    for (int t = 1; t <= 5; t++) send(KIND_LOAD, ADDR_W'(t) << 6);
    send(KIND_STORE, 63'd1 << 6);
    send(KIND_LOAD, 63'd3 << 6);
    send(KIND_MODIFY, (63'd6 << 6) | 63'd15);
    settle();

    // fewer ways with the old contents kept
    apply_config(2, 4, 2);
    send(KIND_LOAD, 63'd3 << 6);
    send(KIND_STORE, 63'd5 << 6);

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      if (ph < 6) begin
        sib  = fixed_sib[ph];
        bob  = fixed_bob[ph];
        ways = fixed_ways[ph];
      end else begin
        sib  = $urandom_range(0, 7);
        case ($urandom_range(0, 3))
          0:       bob = $urandom_range(13, 63);
          1:       bob = $urandom_range(0, 5);
          default: bob = $urandom_range(0, 12);
        endcase
        ways = $urandom_range(0, 7);
      end
      apply_config(sib, bob, ways);
      for (int i = 0; i < 6; i++)
        pool_tag[i] = $urandom_range(0, 1) ? 64'($urandom_range(0, 7)) : {$urandom, $urandom};
      for (int i = 0; i < 3; i++)
        pool_set[i] = 64'($urandom_range(0, 63)) & ((64'd1 << cur_sib) - 64'd1);
      calm = (ph == 4);
      for (int i = 0; i < PHASE_LEN; i++)
        send(KIND_W'($urandom_range(0, 3)), pick_address());
    end
    calm = 1'b0;
    settle();

    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
